// ----- rtl/core/stbs_pkg.sv -----
// ============================================================================
// stbs_pkg
// Shared widths, codes and item types of the sorted table binary search.
// ============================================================================
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int INDEX_W     = 10;
    localparam int KEY_W       = 32;

    localparam logic [KEY_W-1:0] MISS_KEY = '1;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_HOLD
    } state_t;

    typedef struct packed {
        op_t                       operation;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0]   key_value;
    } in_item_t;

    typedef struct packed {
        logic                      found;
        logic signed [KEY_W-1:0]   matched_key;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_table_binary_search.sv -----
// ============================================================================
// sorted_table_binary_search
// Binary search engine over a table of signed keys kept in ascending order.
// ============================================================================
// Channels: the s_ channel carries items (write a key at an index, or search
// for a key); the m_ channel returns one result per search; cfg_ writes the
// element count, taken at any time (cfg_ready is always high).
// A write item gives no result. A search item makes one probe per cycle
// into the single-port key memory: with count n it makes at most
// floor(log2(n))+1 probes, 11 for a full table of 1024. The result register
// loads at the end of the last probe and the next item can be taken in the
// following cycle.
// A search with a count of zero loads its result at the accept edge.
// s_ready is high only while no search is running; a write may follow a write
// in the next cycle.
// The result sits in an output register; if the receiver stalls, a finished
// search waits in a hold state and the next item is taken once the result
// moves into the output register.
// Reset clears the control state and the count; the key memory is not
// cleared, and entries must be written before a search reads them.
// ============================================================================
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg;
    logic signed [KEY_W-1:0] target_reg;
    logic                    hit_reg;
    logic [KEY_W-1:0]        rdata_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic [CNT_W-1:0]        cnt_used;
    logic                    in_acc;
    logic                    search_go;
    logic                    write_go;
    logic                    probe_eq;
    logic                    probe_lt;
    logic [CNT_W-1:0]        lo_step;
    logic [CNT_W-1:0]        hi_step;
    logic                    more;
    logic [ADDR_W-1:0]       mid_step;
    logic                    slot_free;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    finish_valid;
    logic                    finish_hit;
    logic                    load_out;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        cnt_used  = (count_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_reg;
        in_acc    = s_valid && s_ready;
        search_go = in_acc && (s_data.operation == OP_SEARCH);
        write_go  = in_acc && (s_data.operation == OP_WRITE)
                    && ({1'b0, s_data.entry_index} < (INDEX_W+1)'(TABLE_DEPTH));
        probe_eq  = (rdata_reg == target_reg);
        probe_lt  = ($signed(rdata_reg) < target_reg);
        lo_step   = probe_lt ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
        hi_step   = probe_lt ? hi_reg : CNT_W'(mid_reg);
        more      = !probe_eq && (lo_step < hi_step);
        mid_step  = ADDR_W'(lo_step + ((hi_step - lo_step) >> 1));
        slot_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (search_go) begin
                    if (cnt_used != '0) begin
                        state_next = ST_PROBE;
                    end else if (!slot_free) begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_PROBE: begin
                if (!more) begin
                    state_next = slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = mid_step;
        finish_valid = 1'b0;
        finish_hit   = 1'b0;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                lo_next = '0;
                hi_next = cnt_used;
                rd_addr = ADDR_W'(cnt_used >> 1);
                if (search_go) begin
                    rd_en        = (cnt_used != '0);
                    finish_valid = (cnt_used == '0);
                end
            end
            ST_PROBE: begin
                lo_next      = lo_step;
                hi_next      = hi_step;
                rd_en        = more;
                finish_valid = !more;
                finish_hit   = probe_eq;
            end
            ST_HOLD: begin
                finish_valid = 1'b1;
                finish_hit   = hit_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        load_out = finish_valid && slot_free;
    end

    always_ff @(posedge aclk) begin
        if (write_go) begin
            key_mem[ADDR_W'(s_data.entry_index)] <= s_data.key_value;
        end
        if (rd_en) begin
            rdata_reg <= key_mem[rd_addr];
            mid_reg   <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (search_go) begin
            target_reg <= s_data.key_value;
        end
        if (finish_valid) begin
            hit_reg <= finish_hit;
        end
        if (load_out) begin
            m_data_reg.found       <= finish_hit;
            m_data_reg.matched_key <= finish_hit ? target_reg : MISS_KEY;
        end
    end

endmodule

`default_nettype wire
